// ===== design/scon_pkg.sv =====
`default_nettype none

package scon_pkg;

    // Default size of the connection table.
    localparam int SLOTS_DEFAULT = 8;

    // Operation codes.
    localparam logic [2:0] OP_FW_VERSION  = 3'd0;
    localparam logic [2:0] OP_SVC_VERSION = 3'd1;
    localparam logic [2:0] OP_CONNECT     = 3'd2;
    localparam logic [2:0] OP_CLOSE       = 3'd3;

    // Result status codes.
    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_REFUSED  = 3'd1;
    localparam logic [2:0] STATUS_BUSY     = 3'd2;
    localparam logic [2:0] STATUS_PROG_ERR = 3'd3;
    localparam logic [2:0] STATUS_INVALID  = 3'd4;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_FW_VERSION  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SVC_ID      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SVC_VERSION = 2'd2;

    // Configuration register reset values.
    localparam logic [15:0] FW_VERSION_RESET  = 16'd257;
    localparam logic [31:0] SVC_ID_RESET      = 32'd0;
    localparam logic [31:0] SVC_VERSION_RESET = 32'd1;

    // One request beat.
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] service_id;
        logic [31:0] requested_version;
        logic [31:0] close_handle;
    } req_t;

    // One result beat.
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

`default_nettype wire

// ===== design/scon_ctrl.sv =====
`default_nettype none

module scon_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output scon_pkg::cmd_t     cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    // A new request is taken once the result register is free or being drained.
    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign cmd.load  = in_valid && in_ready;
    assign cmd.exec  = (state_reg == ST_EXEC);

    // Next state and result valid flag.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/scon_dp.sv =====
`default_nettype none

module scon_dp #(
    parameter int SLOTS = scon_pkg::SLOTS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire scon_pkg::cmd_t                cmd,
    input  wire scon_pkg::req_t                in_data,
    output scon_pkg::rsp_t                     out_data,
    input  wire logic                          cfg_we,
    input  wire logic [scon_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [15:0]      fw_version_reg;
    logic [31:0]      svc_id_reg;
    logic [31:0]      svc_version_reg;
    scon_pkg::req_t   req_reg;
    scon_pkg::rsp_t   rsp_reg;
    scon_pkg::rsp_t   rsp_next;
    logic [SLOTS-1:0] slot_used_reg;
    logic [SLOTS-1:0] slot_used_next;

    logic [31:0]      query_value;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             handle_in_range;
    logic [31:0]      handle_minus_one;
    logic [IDX_W-1:0] handle_idx;

    assign out_data = rsp_reg;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_version_reg  <= scon_pkg::FW_VERSION_RESET;
            svc_id_reg      <= scon_pkg::SVC_ID_RESET;
            svc_version_reg <= scon_pkg::SVC_VERSION_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                scon_pkg::REG_FW_VERSION:  fw_version_reg  <= cfg_data[15:0];
                scon_pkg::REG_SVC_ID:      svc_id_reg      <= cfg_data;
                scon_pkg::REG_SVC_VERSION: svc_version_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= in_data;
        end
    end

    // Version lookup for the single offered service.
    assign query_value = (req_reg.service_id == svc_id_reg) ? svc_version_reg : 32'd0;

    // Lowest free slot.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = SLOTS - 1; k >= 0; k--)
        begin
            if (!slot_used_reg[k])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(k);
            end
        end
    end

    // Handle decode for close.
    assign handle_in_range  = (req_reg.close_handle != 32'd0) &&
                              (req_reg.close_handle <= 32'(SLOTS));
    assign handle_minus_one = req_reg.close_handle - 32'd1;
    assign handle_idx       = handle_minus_one[IDX_W-1:0];

    // Operation decode and table update.
    always_comb
    begin
        rsp_next.status = scon_pkg::STATUS_OK;
        rsp_next.value  = 32'd0;
        slot_used_next  = slot_used_reg;
        case (req_reg.op)
            scon_pkg::OP_FW_VERSION:
            begin
                rsp_next.value = {16'd0, fw_version_reg};
            end
            scon_pkg::OP_SVC_VERSION:
            begin
                rsp_next.value = query_value;
            end
            scon_pkg::OP_CONNECT:
            begin
                if (query_value == 32'd0)
                begin
                    rsp_next.status = scon_pkg::STATUS_REFUSED;
                end
                else if ((req_reg.requested_version != 32'd0) &&
                         (req_reg.requested_version > svc_version_reg))
                begin
                    rsp_next.status = scon_pkg::STATUS_REFUSED;
                end
                else if (!free_found)
                begin
                    rsp_next.status = scon_pkg::STATUS_BUSY;
                end
                else
                begin
                    slot_used_next[free_idx] = 1'b1;
                    rsp_next.value = 32'(free_idx) + 32'd1;
                end
            end
            scon_pkg::OP_CLOSE:
            begin
                if (handle_in_range && slot_used_reg[handle_idx])
                begin
                    slot_used_next[handle_idx] = 1'b0;
                end
                else
                begin
                    rsp_next.status = scon_pkg::STATUS_PROG_ERR;
                end
            end
            default:
            begin
                rsp_next.status = scon_pkg::STATUS_INVALID;
            end
        endcase
    end

    // Slot table, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_used_reg <= '0;
        end
        else if (cmd.exec)
        begin
            slot_used_reg <= slot_used_next;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/service_connection_table.sv =====
// Timing: a request beat is captured, then executed in the controller's execute
// state, and its result beat is registered as the controller leaves that state.
// Flow: a new request is taken only after the previous one has passed the
// capture step and the execute step of the controller; a waiting result stalls the next request.
// Reset: asynchronous, active low; all connection slots are freed and the
// configuration registers take their reset values at once.
`default_nettype none

module service_connection_table #(
    parameter int SLOTS = scon_pkg::SLOTS_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire scon_pkg::req_t                   in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output scon_pkg::rsp_t                        out_data,
    input  wire logic                             cfg_we,
    input  wire logic [scon_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]                      cfg_data
);

    scon_pkg::cmd_t cmd;

    // Sequencing of capture, execute and result hand-off.
    scon_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Registers, slot table and result computation.
    scon_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

// ===== design/scon_checker.sv =====
`default_nettype none

module scon_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           in_valid,
    input wire logic           in_ready,
    input wire scon_pkg::req_t in_data,
    input wire logic           out_valid,
    input wire logic           out_ready,
    input wire scon_pkg::rsp_t out_data
);

    // A result beat that is stalled holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

    // Every accepted request produces a result beat after its execute state.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 out_valid)
    else $error("result beat missing after request");

    // No new request is taken while one is executing.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("request accepted during execution");

    // Status codes stay within the defined set.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status <= scon_pkg::STATUS_INVALID)
    else $error("undefined status code");

    // Only successful results carry a value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != scon_pkg::STATUS_OK) |-> out_data.value == 32'd0)
    else $error("value on a failed result");

endmodule

bind service_connection_table scon_checker u_scon_checker (.*);

`default_nettype wire
